// ===== rtl/vweld_pkg.sv =====
// Package for the vertex welding block.
// Holds command codes and the fixed field widths used by the top level and the compare unit.
// No dependencies.
package vweld_pkg;

  localparam int IDX_W  = 10;
  localparam int TOL_W  = 31;
  localparam int DIFF_W = 34;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_REMAP  = 2'd2;

endpackage

// ===== rtl/vertex_weld_by_position.sv =====
// Top level of the vertex welding block: sequencer, survivor and remap memories, result register.
// Depends on vweld_pkg and vweld_cmp.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    cmd, pos_x, pos_y, pos_z, old_index
//   out       output     out_valid / out_ready  new_index, is_new, error
//   cfg       input      cfg_wr_en              cfg_wr_data (match tolerance)
//
// A vertex is compared with the survivors one after another: the survivor memory has one
// read port and the compare unit checks one survivor per cycle. Reset clears the counts and
// sets the tolerance to 1; the memories are not cleared. A new transfer is taken while a
// result still waits at the output.
module vertex_weld_by_position #(
  parameter int MAX_VERTS   = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  input  logic signed [31:0]            pos_z,
  input  logic [vweld_pkg::IDX_W-1:0]   old_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vweld_pkg::IDX_W-1:0]   new_index,
  output logic                          is_new,
  output logic                          error,
  input  logic                          cfg_wr_en,
  input  logic [vweld_pkg::TOL_W-1:0]   cfg_wr_data
);
  import vweld_pkg::*;

  localparam int CNT_W  = $clog2(MAX_VERTS + 1);
  localparam int ADDR_W = $clog2(MAX_VERTS);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int OUT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REMAP  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]                  state;
  logic [TOL_W-1:0]            tol;
  logic signed [DIFF_W-1:0]    tol_neg;
  logic [CNT_W-1:0]            vertex_count;
  logic [CNT_W-1:0]            survivor_count;
  logic [2:0][COORD_WIDTH-1:0] pos;
  logic [CNT_W-1:0]            scan_idx;
  logic                        v1;
  logic                        v2;
  logic [ADDR_W-1:0]           idx1;
  logic [ADDR_W-1:0]           idx2;
  logic [2:0][COORD_WIDTH-1:0] surv_rd;
  logic [ADDR_W-1:0]           remap_rd;
  logic [ADDR_W-1:0]           res_idx;
  logic                        res_new;
  logic                        res_err;
  logic                        res_commit;
  logic [ADDR_W-1:0]           out_idx;
  logic [OUT_W-1:0]            out_idx_ext;
  logic [CMP_W-1:0]            old_index_ext;

  logic [2:0][COORD_WIDTH-1:0] surv_mem [MAX_VERTS];
  logic [ADDR_W-1:0]           remap_mem [MAX_VERTS];

  logic accept;
  logic issue;
  logic cmp_match;
  logic hit;
  logic scan_end;
  logic load;
  logic commit;

  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign old_index_ext = CMP_W'(old_index);
  assign issue         = (state == S_SCAN) && (scan_idx < survivor_count) && !hit;
  assign hit           = v2 && cmp_match;
  assign scan_end      = (state == S_SCAN) && !hit && !issue && !v1;
  assign load          = (state == S_RESULT) && (!out_valid || out_ready);
  assign commit        = load && res_commit;

  always_ff @(posedge clk) begin
    if (issue) begin
      surv_rd <= surv_mem[scan_idx[ADDR_W-1:0]];
    end
    if (commit && res_new) begin
      surv_mem[survivor_count[ADDR_W-1:0]] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      remap_rd <= remap_mem[old_index_ext[ADDR_W-1:0]];
    end
    if (commit) begin
      remap_mem[vertex_count[ADDR_W-1:0]] <= res_idx;
    end
  end

  vweld_cmp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cmp (
    .clk    (clk),
    .en     (v1),
    .pos_a  (pos),
    .pos_b  (surv_rd),
    .tol    (tol),
    .tol_neg(tol_neg),
    .match  (cmp_match)
  );

  always_ff @(posedge clk) begin
    idx1 <= scan_idx[ADDR_W-1:0];
    idx2 <= idx1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tol            <= TOL_W'(1);
      tol_neg        <= -DIFF_W'(1);
      vertex_count   <= '0;
      survivor_count <= '0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol     <= cfg_wr_data;
        tol_neg <= -$signed({{(DIFF_W-TOL_W){1'b0}}, cfg_wr_data});
      end

      v1 <= issue;
      v2 <= v1 && (state == S_SCAN) && !hit;

      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_idx    <= '0;
            res_new    <= 1'b0;
            res_err    <= 1'b1;
            res_commit <= 1'b0;
            state      <= S_RESULT;
            unique case (cmd)
              CMD_CLEAR: begin
                vertex_count   <= '0;
                survivor_count <= '0;
                res_err        <= 1'b0;
              end
              CMD_VERTEX: begin
                if (vertex_count != CNT_W'(MAX_VERTS)) begin
                  pos      <= {pos_z[COORD_WIDTH-1:0], pos_y[COORD_WIDTH-1:0],
                               pos_x[COORD_WIDTH-1:0]};
                  scan_idx <= '0;
                  state    <= S_SCAN;
                end
              end
              CMD_REMAP: begin
                if (old_index_ext < CMP_W'(vertex_count)) begin
                  state <= S_REMAP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (hit) begin
            res_idx    <= idx2;
            res_new    <= 1'b0;
            res_err    <= 1'b0;
            res_commit <= 1'b1;
            state      <= S_RESULT;
          end else if (scan_end) begin
            res_idx    <= survivor_count[ADDR_W-1:0];
            res_new    <= 1'b1;
            res_err    <= 1'b0;
            res_commit <= 1'b1;
            state      <= S_RESULT;
          end
        end
        S_REMAP: begin
          res_idx <= remap_rd;
          res_err <= 1'b0;
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (load) begin
            if (res_commit) begin
              vertex_count <= vertex_count + CNT_W'(1);
              if (res_new) begin
                survivor_count <= survivor_count + CNT_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx <= res_idx;
      is_new  <= res_new;
      error   <= res_err;
    end
  end

  assign out_idx_ext = OUT_W'(out_idx);
  assign new_index   = out_idx_ext[IDX_W-1:0];

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    survivor_count <= vertex_count)
    else $error("More survivors than vertices.");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_W'(MAX_VERTS))
    else $error("Vertex count beyond table depth.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!v1 && !v2))
    else $error("Scan pipeline active while idle.");

  a_new_index: assert property (@(posedge clk) disable iff (rst)
    (commit && res_new) |-> (res_idx == survivor_count[ADDR_W-1:0]))
    else $error("New survivor not numbered by the survivor count.");

endmodule

// ===== rtl/vweld_cmp.sv =====
// Position compare unit of the vertex welding block.
// Registers the three coordinate differences, then checks them against the tolerance.
// Depends on vweld_pkg.
module vweld_cmp #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][COORD_WIDTH-1:0]         pos_a,
  input  logic [2:0][COORD_WIDTH-1:0]         pos_b,
  input  logic [vweld_pkg::TOL_W-1:0]         tol,
  input  logic signed [vweld_pkg::DIFF_W-1:0] tol_neg,
  output logic                                match
);
  import vweld_pkg::*;

  logic signed [DIFF_W-1:0] diff [3];
  logic signed [DIFF_W-1:0] tol_pos;
  logic [2:0]               coord_ok;

  assign tol_pos = $signed({{(DIFF_W-TOL_W){1'b0}}, tol});

  for (genvar k = 0; k < 3; k++) begin : g_coord
    always_ff @(posedge clk) begin
      if (en) begin
        diff[k] <= $signed({{(DIFF_W-COORD_WIDTH){pos_a[k][COORD_WIDTH-1]}}, pos_a[k]}) -
                   $signed({{(DIFF_W-COORD_WIDTH){pos_b[k][COORD_WIDTH-1]}}, pos_b[k]});
      end
    end

    assign coord_ok[k] = (diff[k] == '0) || ((diff[k] < tol_pos) && (diff[k] > tol_neg));
  end

  assign match = &coord_ok;

endmodule
